### design/pdro_pkg.sv
// ----------------------------------------------------------------------------
// pdro_pkg: shared types and constants
// Field widths, multiplier operand codes and the control/status bundles that
// run between the controller and the datapath of the resonance oscillator.
// ----------------------------------------------------------------------------
package pdro_pkg;

   // item field widths
   localparam int INC_W    = 23;
   localparam int TGT_W    = 16;
   localparam int SAMPLE_W = 16;

   // one-pole smoother: alpha = round(0.0007 * 2^24)
   localparam int ALPHA_Q24    = 11744;
   localparam int SMOOTH_SHIFT = 24;

   // window in Q16, 1.0 = 2^16
   localparam int WIN_W = 17;

   // resonance multiplier 65536 + 15 * index
   localparam int RMULT_W = 20;

   // shared signed multiplier
   localparam int MUL_AW = 25;
   localparam int MUL_BW = 21;
   localparam int MUL_W  = MUL_AW + MUL_BW;

   typedef enum logic [1:0] {
      MUL_SMOOTH,
      MUL_RESO,
      MUL_OUT
   } mul_sel_type;

   typedef struct packed {
      logic        load;     // take the item, read the cosine table
      logic        phase;    // step master phase, detect sync, build window
      logic        mul_en;   // register the shared product
      mul_sel_type mul_sel;
      logic        sadd;     // finish smoothing
      logic        rupd;     // commit resonance and master phase
      logic        emit;     // load the result register
   } cmd_type;

   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage

### design/pdro_if.sv
// ----------------------------------------------------------------------------
// pdro_if: item channels
// Valid/ready channels for the sample tick going in and the sample coming out.
// ----------------------------------------------------------------------------
interface pdro_req_if;
   import pdro_pkg::*;

   logic             valid;
   logic             ready;
   logic [INC_W-1:0] phase_increment;
   logic [TGT_W-1:0] target_mod_index;
   logic             key_on;

   modport source (output valid, output phase_increment, output target_mod_index,
                   output key_on, input ready);
   modport sink   (input valid, input phase_increment, input target_mod_index,
                   input key_on, output ready);
endinterface

interface pdro_rsp_if;
   import pdro_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample_out;
   logic                       sync_pulse;
   logic                       scope_pulse;

   modport source (output valid, output sample_out, output sync_pulse,
                   output scope_pulse, input ready);
   modport sink   (input valid, input sample_out, input sync_pulse,
                   input scope_pulse, output ready);
endinterface

### design/pdro_ctrl.sv
// ----------------------------------------------------------------------------
// pdro_ctrl: sequencer
// Steps one item through the shared multiplier: smoothing, resonance step,
// output scaling, then hands the sample to the result register.
// ----------------------------------------------------------------------------
module pdro_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  pdro_pkg::stat_type stat,
   output pdro_pkg::cmd_type  cmd
);
   import pdro_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_SMUL = 7'b0000010,
      ST_SADD = 7'b0000100,
      ST_RMUL = 7'b0001000,
      ST_RUPD = 7'b0010000,
      ST_OMUL = 7'b0100000,
      ST_EMIT = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      cmd         = '0;
      cmd.mul_sel = MUL_SMOOTH;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SMUL;
            end
         end
         ST_SMUL: begin
            cmd.phase   = 1'b1;
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_SMOOTH;
            state_in    = ST_SADD;
         end
         ST_SADD: begin
            cmd.sadd = 1'b1;
            state_in = ST_RMUL;
         end
         ST_RMUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_RESO;
            state_in    = ST_RUPD;
         end
         ST_RUPD: begin
            cmd.rupd = 1'b1;
            state_in = ST_OMUL;
         end
         ST_OMUL: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_OUT;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the result register frees up
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### design/pdro_datapath.sv
// ----------------------------------------------------------------------------
// pdro_datapath: phases, smoother, cosine table and shared multiplier
// Holds the oscillator state and the result register; every step is started
// by a command from the sequencer.
// ----------------------------------------------------------------------------
module pdro_datapath #(
   parameter int PHASE_BITS      = 24,
   parameter int COS_TABLE_DEPTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pdro_pkg::cmd_type                    cmd,
   output pdro_pkg::stat_type                   stat,
   input  logic [pdro_pkg::INC_W-1:0]           phase_increment,
   input  logic [pdro_pkg::TGT_W-1:0]           target_mod_index,
   input  logic                                 key_on,
   input  logic                                 rsp_ready,
   output logic                                 rsp_valid,
   output logic signed [pdro_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output logic                                 rsp_sync_pulse,
   output logic                                 rsp_scope_pulse
);
   import pdro_pkg::*;

   localparam int PB     = PHASE_BITS;
   localparam int IW     = $clog2(COS_TABLE_DEPTH);
   localparam int SUM_W  = ((PB + 1) > INC_W ? (PB + 1) : INC_W) + 1;
   localparam int FRAC   = 16;
   localparam longint Q30_ONE     = 64'sd1 << 30;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;

   typedef logic signed [SAMPLE_W-1:0] cos_rom_type [COS_TABLE_DEPTH];

   // cosine of a Q0.32 turn in Q1.15, Taylor series in Q30
   function automatic logic signed [SAMPLE_W-1:0] cos_q15(input logic [31:0] turn);
      logic [1:0] quad;
      longint     r;
      longint     x;
      longint     x2;
      longint     h;
      longint     c;
      longint     v;
      quad = turn[31:30];
      r    = longint'(turn[29:0]);
      if (quad[0]) begin
         r = Q30_ONE - r;
      end
      x  = (r * HALF_PI_Q30) >>> 30;
      x2 = (x * x) >>> 30;
      h  = Q30_ONE - x2 / 90;
      h  = Q30_ONE - (x2 * h) / (56 * Q30_ONE);
      h  = Q30_ONE - (x2 * h) / (30 * Q30_ONE);
      h  = Q30_ONE - (x2 * h) / (12 * Q30_ONE);
      c  = Q30_ONE - (x2 * h) / (2 * Q30_ONE);
      if (c >= 0) begin
         v = (c + 16384) / 32768;
      end else begin
         v = -((-c + 16384) / 32768);
      end
      if (v > 32767) begin
         v = 32767;
      end
      if (v < -32767) begin
         v = -32767;
      end
      if (quad == 2'd1 || quad == 2'd2) begin
         v = -v;
      end
      return SAMPLE_W'(v);
   endfunction

   function automatic cos_rom_type build_cos_rom();
      cos_rom_type rom;
      logic [31:0] turn;
      for (int k = 0; k < COS_TABLE_DEPTH; k++) begin
         turn   = 32'((64'(k) << 32) / COS_TABLE_DEPTH);
         rom[k] = cos_q15(turn);
      end
      return rom;
   endfunction

   localparam cos_rom_type COS_ROM = build_cos_rom();

   // oscillator state
   logic [PB:0]       master_ff;
   logic [PB-1:0]     reso_ff;
   logic [TGT_W-1:0]  smooth_ff;

   // item and intermediate registers
   logic [INC_W-1:0]            inc_ff;
   logic [TGT_W-1:0]            tgt_ff;
   logic signed [SAMPLE_W-1:0]  cos_ff;
   logic [PB:0]                 next_ff;
   logic                        sync_ff;
   logic                        oldbit_ff;
   logic [WIN_W-1:0]            win_ff;
   logic signed [MUL_W-1:0]     mul_ff;

   // result register
   logic                        rsp_valid_ff;
   logic signed [SAMPLE_W-1:0]  rsp_sample_ff;
   logic                        rsp_sync_ff;
   logic                        rsp_scope_ff;

   logic [PB+IW-1:0]            cos_idx_wide;
   logic [IW-1:0]               cos_idx;
   logic [PB-1:0]               pos;
   logic [PB:0]                 next_phase;
   logic [PB:0]                 win_rem;
   logic [PB+17:0]              win_wide;
   logic [WIN_W-1:0]            win_ramp;
   logic [TGT_W:0]              smooth_diff;
   logic [RMULT_W-1:0]          reso_mult;
   logic [SAMPLE_W:0]           out_diff;
   logic signed [MUL_AW-1:0]    mul_a;
   logic signed [MUL_BW-1:0]    mul_b;
   logic signed [MUL_W-1:0]     smooth_round;
   logic [PB+FRAC-1:0]          mul_ext;
   logic [PB-1:0]               rinc;
   logic [32:0]                 out_round;
   logic [SAMPLE_W:0]           out_q;
   logic signed [SAMPLE_W-1:0]  sample;

   assign cos_idx_wide = (PB+IW)'(reso_ff) * (PB+IW)'(COS_TABLE_DEPTH);
   assign cos_idx      = IW'(cos_idx_wide >> PB);

   // master phase step and falling window over the second half cycle
   assign pos        = master_ff[PB-1:0];
   assign next_phase = (PB+1)'(SUM_W'(master_ff) + SUM_W'(inc_ff));
   assign win_rem    = {1'b1, {PB{1'b0}}} - {1'b0, pos};
   assign win_wide   = {win_rem, 17'd0} >> PB;
   assign win_ramp   = WIN_W'(win_wide);

   assign smooth_diff = {1'b0, tgt_ff} - {1'b0, smooth_ff};
   assign reso_mult   = RMULT_W'(32'h10000) + ({4'd0, smooth_ff} << 4) - {4'd0, smooth_ff};
   assign out_diff    = 17'h08000 - 17'(cos_ff);

   always_comb begin
      case (cmd.mul_sel)
         MUL_SMOOTH: begin
            mul_a = MUL_AW'(signed'(smooth_diff));
            mul_b = MUL_BW'(ALPHA_Q24);
         end
         MUL_RESO: begin
            mul_a = MUL_AW'(inc_ff);
            mul_b = MUL_BW'(reso_mult);
         end
         MUL_OUT: begin
            mul_a = MUL_AW'(out_diff);
            mul_b = MUL_BW'(win_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign smooth_round = mul_ff + MUL_W'(1 << (SMOOTH_SHIFT - 1));
   assign mul_ext      = (PB+FRAC)'(mul_ff);
   assign rinc         = mul_ext[PB+FRAC-1:FRAC];
   assign out_round    = {1'b0, mul_ff[31:0]} + 33'h8000;
   assign out_q        = out_round[32:16];
   assign sample       = (out_q == '0) ? 16'sh7fff : SAMPLE_W'(17'h08000 - out_q);

   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         inc_ff <= phase_increment;
         tgt_ff <= target_mod_index;
         cos_ff <= COS_ROM[cos_idx];
      end
      if (cmd.phase) begin
         next_ff   <= next_phase;
         oldbit_ff <= master_ff[PB];
         sync_ff   <= master_ff[PB] ^ next_phase[PB];
         win_ff    <= pos[PB-1] ? win_ramp : WIN_W'(32'h10000);
      end
      if (cmd.mul_en) begin
         mul_ff <= mul_a * mul_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         master_ff <= '0;
         reso_ff   <= '0;
         smooth_ff <= '0;
      end else begin
         if (cmd.load && key_on) begin
            master_ff <= '0;
         end else if (cmd.rupd) begin
            master_ff <= next_ff;
         end
         if (cmd.sadd) begin
            smooth_ff <= smooth_ff + smooth_round[SMOOTH_SHIFT+TGT_W-1:SMOOTH_SHIFT];
         end
         if (cmd.rupd) begin
            // hard sync clears the resonance phase after its step
            reso_ff <= sync_ff ? '0 : reso_ff + rinc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_sample_ff <= sample;
         rsp_sync_ff   <= sync_ff;
         rsp_scope_ff  <= sync_ff && !oldbit_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample_out  = rsp_sample_ff;
   assign rsp_sync_pulse  = rsp_sync_ff;
   assign rsp_scope_pulse = rsp_scope_ff;

   a_sync_clears_reso: assert property (@(posedge clock) disable iff (reset)
      cmd.rupd && sync_ff |=> reso_ff == '0)
      else $error("resonance phase not cleared on hard sync");

   a_smooth_bounded: assert property (@(posedge clock) disable iff (reset)
      cmd.sadd |=> (smooth_ff >= $past(smooth_ff) && smooth_ff <= $past(tgt_ff)) ||
                   (smooth_ff <= $past(smooth_ff) && smooth_ff >= $past(tgt_ff)))
      else $error("smoothed index left the span between old value and target");

   a_emit_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_valid_ff)
      else $error("emitted item not presented");

   a_scope_needs_sync: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_scope_ff |-> rsp_sync_ff)
      else $error("scope trigger without hard sync");

endmodule

### design/phase_distortion_reso_oscillator.sv
// ----------------------------------------------------------------------------
// phase_distortion_reso_oscillator: resonance oscillator, one sample per item
// Master phase with hard sync, windowed resonance cosine, smoothed depth.
// ----------------------------------------------------------------------------
//  channel    direction  payload
//  req_chan   in         phase_increment, target_mod_index, key_on
//  rsp_chan   out        sample_out, sync_pulse, scope_pulse
//
//  An item passes through the accept cycle, five steps around the single
//  shared 25x21 multiplier (smoothing, resonance step, output scaling) and
//  the write of the result register. The next item is accepted after that.
//  Reset clears master phase, resonance phase and smoothed index.
//  A stalled result holds the sequencer in its last step; one finished item
//  may wait on rsp_chan while the next one is taken in and worked on.
// ----------------------------------------------------------------------------
module phase_distortion_reso_oscillator #(
   parameter int PHASE_BITS      = 24,
   parameter int COS_TABLE_DEPTH = 1024
) (
   input logic        clock,
   input logic        reset,
   pdro_req_if.sink   req_chan,
   pdro_rsp_if.source rsp_chan
);
   import pdro_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   pdro_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   pdro_datapath #(
      .PHASE_BITS      (PHASE_BITS),
      .COS_TABLE_DEPTH (COS_TABLE_DEPTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .phase_increment  (req_chan.phase_increment),
      .target_mod_index (req_chan.target_mod_index),
      .key_on           (req_chan.key_on),
      .rsp_ready        (rsp_chan.ready),
      .rsp_valid        (rsp_chan.valid),
      .rsp_sample_out   (rsp_chan.sample_out),
      .rsp_sync_pulse   (rsp_chan.sync_pulse),
      .rsp_scope_pulse  (rsp_chan.scope_pulse)
   );

endmodule

### sim/tb_phase_distortion_reso_oscillator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_phase_distortion_reso_oscillator: self-checking bench for the oscillator
// Sends sample ticks with directed extremes, then random note sequences under
// several idle and stall mixes, and checks every sample against a bit-exact
// predictor of phase, sync, smoothing, cosine lookup and window scaling.
// ----------------------------------------------------------------------------
module tb_phase_distortion_reso_oscillator;
   import pdro_pkg::*;

   localparam int PHASE_BITS   = 24;
   localparam int COS_DEPTH    = 1024;
   localparam int DRAIN_CYCLES = 24;
   localparam int MAX_PRINTS   = 40;

   localparam longint          Q30_ONE     = 64'sd1 << 30;
   localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
   localparam longint unsigned PHASE_FULL  = 64'd1 << PHASE_BITS;
   localparam longint unsigned PHASE_MASK  = PHASE_FULL - 1;
   localparam longint unsigned MASTER_MASK = (PHASE_FULL << 1) - 1;
   localparam logic [INC_W-1:0] INC_MAX    = '1;
   localparam logic [TGT_W-1:0] TGT_MAX    = '1;

   typedef struct {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       sync;
      logic                       scope;
   } sample_type;

   logic clock = 1'b0;
   logic reset;

   pdro_req_if req_chan ();
   pdro_rsp_if rsp_chan ();

   phase_distortion_reso_oscillator #(
      .PHASE_BITS      (PHASE_BITS),
      .COS_TABLE_DEPTH (COS_DEPTH)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #6 clock = ~clock;

   // predictor state
   longint unsigned master_phase;
   longint unsigned reso_phase;
   longint unsigned smoothed_index;

   sample_type pending_samples[$];
   int         error_count    = 0;
   int         send_idle_pct  = 0;
   int         rsp_stall_pct  = 0;

   // cosine of a Q0.32 turn in Q1.15: quadrant fold, Q30 series to x^10
   function automatic longint cos_q15(input logic [31:0] turn);
      logic [1:0]      quad;
      longint unsigned r, x, x2;
      longint          h, c, v;
      quad = turn[31:30];
      r    = {34'd0, turn[29:0]};
      if (quad[0]) begin
         r = (64'd1 << 30) - r;
      end
      x  = (r * HALF_PI_Q30) >> 30;
      x2 = (x * x) >> 30;
      h  = Q30_ONE - longint'(x2) / 90;
      h  = Q30_ONE - (longint'(x2) * h) / (56 * Q30_ONE);
      h  = Q30_ONE - (longint'(x2) * h) / (30 * Q30_ONE);
      h  = Q30_ONE - (longint'(x2) * h) / (12 * Q30_ONE);
      c  = Q30_ONE - (longint'(x2) * h) / (2 * Q30_ONE);
      if (c >= 0) begin
         v = (c + 16384) / 32768;
      end else begin
         v = -((-c + 16384) / 32768);
      end
      if (v > 32767) v = 32767;
      if (v < -32767) v = -32767;
      if (quad == 2'd1 || quad == 2'd2) v = -v;
      return v;
   endfunction

   // advance the oscillator by one tick and return the sample it produces
   function automatic sample_type predict_sample(input logic [INC_W-1:0] inc,
                                                 input logic [TGT_W-1:0] tgt,
                                                 input logic key);
      sample_type      res;
      longint unsigned pos, next_phase, rinc, idx, w, d, prod;
      logic            oldbit, sync;
      logic [31:0]     turn;
      longint          c, y;
      if (key) master_phase = 0;
      smoothed_index = (smoothed_index * ((64'd1 << 24) - ALPHA_Q24)
                        + longint'(tgt) * ALPHA_Q24 + (64'd1 << 23)) >> SMOOTH_SHIFT;

      pos        = master_phase & PHASE_MASK;
      oldbit     = master_phase[PHASE_BITS];
      next_phase = (master_phase + inc) & MASTER_MASK;
      sync       = oldbit != next_phase[PHASE_BITS];

      // table index uses the resonance phase before this tick's step
      idx  = ((reso_phase & PHASE_MASK) * COS_DEPTH) >> PHASE_BITS;
      turn = 32'((idx << 32) / COS_DEPTH);
      c    = cos_q15(turn);
      rinc = (longint'(inc) * (64'd65536 + 15 * smoothed_index)) >> 16;
      reso_phase = (reso_phase + rinc) & PHASE_MASK;
      if (sync) reso_phase = 0;
      master_phase = next_phase;

      if (pos < (PHASE_FULL >> 1)) begin
         w = 65536;
      end else begin
         w = ((PHASE_FULL - pos) << 17) >> PHASE_BITS;
      end
      d    = longint'(32768 - c);
      prod = (d * w + 32768) >> 16;
      y    = 32768 - longint'(prod);
      if (y > 32767) y = 32767;

      res.sample = y[SAMPLE_W-1:0];
      res.sync   = sync;
      res.scope  = sync && !oldbit;
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      if (error_count < MAX_PRINTS) $display("%0t ns: %s", $time, msg);
      error_count++;
   endtask

   task automatic send_tick(input logic [INC_W-1:0] inc, input logic [TGT_W-1:0] tgt,
                            input logic key);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid            <= 1'b1;
      req_chan.phase_increment  <= inc;
      req_chan.target_mod_index <= tgt;
      req_chan.key_on           <= key;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      pending_samples.push_back(predict_sample(inc, tgt, key));
   endtask

   task automatic wait_drained();
      int guard;
      guard = 0;
      req_chan.valid <= 1'b0;
      while (pending_samples.size() != 0 && guard < 20000) begin
         @(posedge clock);
         guard++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // result side: random stalls and comparison against the oldest prediction
   always @(posedge clock) begin
      sample_type exp_s;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
            if (pending_samples.size() == 0) begin
               report_mismatch("sample with no tick pending");
            end else begin
               exp_s = pending_samples.pop_front();
               if (rsp_chan.sample_out !== exp_s.sample)
                  report_mismatch($sformatf("sample_out %0d, want %0d",
                                            rsp_chan.sample_out, exp_s.sample));
               if (rsp_chan.sync_pulse !== exp_s.sync)
                  report_mismatch($sformatf("sync_pulse %b, want %b",
                                            rsp_chan.sync_pulse, exp_s.sync));
               if (rsp_chan.scope_pulse !== exp_s.scope)
                  report_mismatch($sformatf("scope_pulse %b, want %b",
                                            rsp_chan.scope_pulse, exp_s.scope));
            end
         end
         rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // idle state, full-scale increment and target, both sync directions
   task automatic test_extremes();
      send_tick('0, '0, 1'b0);
      send_tick(INC_MAX, TGT_MAX, 1'b0);
      repeat (5) send_tick(INC_MAX, TGT_MAX, 1'b0);
      send_tick(INC_MAX, '0, 1'b0);
      send_tick(23'h555555, 16'haaaa, 1'b0);
      send_tick(23'h2aaaaa, 16'h5555, 1'b0);
   endtask

   // key-on clears only the master phase, also from the second half
   task automatic test_key_on();
      send_tick(23'h600000, 16'h8000, 1'b0);
      send_tick(23'h100000, 16'h8000, 1'b1);
      send_tick('0, TGT_MAX, 1'b1);
      send_tick(INC_MAX, TGT_MAX, 1'b1);
   endtask

   // quarter-cycle steps hit half cycle exactly and the window slope
   task automatic test_window_steps();
      send_tick(23'h400000, '0, 1'b1);
      repeat (8) send_tick(23'h400000, '0, 1'b0);
      send_tick(23'd1, TGT_MAX, 1'b0);
   endtask

   // random notes: optional key-on, held increment, mostly held target, occasional noise ticks
   task automatic test_random_notes(input int n_items);
      int               sent, note_len, cls;
      logic [INC_W-1:0] inc;
      logic [TGT_W-1:0] tgt;
      logic             key;
      sent = 0;
      while (sent < n_items) begin
         note_len = $urandom_range(4, 60);
         cls      = $urandom_range(0, 9);
         if (cls == 0)      inc = INC_W'($urandom_range(0, 255));
         else if (cls == 1) inc = INC_W'($urandom);
         else               inc = INC_W'($urandom_range(1 << 16, (1 << INC_W) - 1));
         tgt = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? TGT_MAX : '0)
                                            : TGT_W'($urandom);
         key = 1'($urandom_range(0, 1));
         for (int i = 0; i < note_len && sent < n_items; i++) begin
            if ($urandom_range(0, 99) < 5) begin
               send_tick(INC_W'($urandom), TGT_W'($urandom), 1'($urandom));
            end else begin
               if ($urandom_range(0, 99) < 10) tgt = TGT_W'($urandom);
               send_tick(inc, tgt, key);
               key = 1'b0;
            end
            sent++;
         end
      end
   endtask

   initial begin
      reset                     <= 1'b1;
      req_chan.valid            <= 1'b0;
      req_chan.phase_increment  <= '0;
      req_chan.target_mod_index <= '0;
      req_chan.key_on           <= 1'b0;
      master_phase   = 0;
      reso_phase     = 0;
      smoothed_index = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_extremes();
      test_key_on();
      test_window_steps();
      wait_drained();

      send_idle_pct = 0;  rsp_stall_pct = 0;
      test_random_notes(440);
      wait_drained();
      send_idle_pct = 62; rsp_stall_pct = 0;
      test_random_notes(440);
      wait_drained();
      send_idle_pct = 0;  rsp_stall_pct = 62;
      test_random_notes(440);
      wait_drained();
      send_idle_pct = 8;  rsp_stall_pct = 8;
      test_random_notes(440);
      wait_drained();

      if (pending_samples.size() != 0)
         report_mismatch($sformatf("%0d samples never arrived", pending_samples.size()));
      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
